@@ hdl/lflx_pkg.sv @@
// Shared types and constants for the Lax-Friedrichs flux splitting unit.
package lflx_pkg;

	localparam int GAMMA_FRAC  = 16;
	localparam int HEAT_W      = 18;
	localparam int NUM_W       = 50;
	localparam int DIV_STEPS   = 50;
	localparam int SQRT_STEPS  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [HEAT_W-1:0] HEAT_RESET = 18'd91750;

	typedef logic signed [62:0] val_t;
	typedef logic [32:0] speed_t;
	typedef logic signed [47:0] flux_t;
	typedef logic signed [33:0] mulb_t;
	typedef logic [3:0] step_t;

	localparam val_t SAT_POS = {1'b0, {62{1'b1}}};
	localparam speed_t SPEED_MAX = {33{1'b1}};

	localparam step_t STEP_RU  = 4'd0;
	localparam step_t STEP_RV  = 4'd1;
	localparam step_t STEP_RUV = 4'd2;
	localparam step_t STEP_RUU = 4'd3;
	localparam step_t STEP_RVV = 4'd4;
	localparam step_t STEP_EPU = 4'd5;
	localparam step_t STEP_EPV = 4'd6;
	localparam step_t STEP_SQ0 = 4'd7;
	localparam step_t STEP_END = 4'd14;

	typedef enum logic {
		KIND_MEASURE = 1'b0,
		KIND_SPLIT   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               first;
		logic [31:0]        density;
		logic [31:0]        pressure;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [31:0]        energy;
	} cell_t;

	typedef struct packed {
		logic  start;
		val_t  a;
		mulb_t b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		val_t prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] density;
		logic [31:0] pressure;
	} root_req_t;

	typedef struct packed {
		logic   done;
		speed_t speed;
	} root_rsp_t;

	typedef struct packed {
		logic            dir;
		flux_t [3:0]     plus;
		flux_t [3:0]     minus;
	} res_t;

	typedef enum logic [2:0] {
		RT_IDLE,
		RT_MUL,
		RT_DIV,
		RT_SQRT,
		RT_DONE
	} root_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROOT,
		BK_ISSUE,
		BK_WAIT,
		BK_SUM,
		BK_HALF,
		BK_EMIT
	} back_state_t;

endpackage

@@ hdl/lflx_front.sv @@
// Input side: accepts cells, classifies them and queues them for the back end.
module lflx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               req_type,
	input  logic               first,
	input  logic [31:0]        density,
	input  logic [31:0]        pressure,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [31:0]        energy,
	output logic               cell_valid,
	output lflx_pkg::cell_t    cell_data,
	input  logic               cell_take
);
	import lflx_pkg::*;

	cell_t      entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cell_t      incoming;
	logic       wr_en;
	logic       rd_en;

	always_comb begin
		incoming.kind     = req_type ? KIND_SPLIT : KIND_MEASURE;
		incoming.first    = first & ~req_type;
		incoming.density  = density;
		incoming.pressure = pressure;
		incoming.vel_x    = vel_x;
		incoming.vel_y    = vel_y;
		incoming.energy   = energy;
	end

	assign full       = (count_q == 2'(QUEUE_DEPTH));
	assign cell_valid = (count_q != '0);
	assign cell_data  = entry_q[rd_ptr_q];
	assign wr_en      = push & ~full;
	assign rd_en      = cell_take & cell_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 2'd1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			entry_q[wr_ptr_q] <= incoming;
	end

endmodule

@@ hdl/lflx_mul.sv @@
// Pipelined fixed-point multiplier with truncation toward zero and saturation.
module lflx_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lflx_pkg::mul_req_t req,
	output lflx_pkg::mul_rsp_t rsp
);
	import lflx_pkg::*;

	val_t        a_abs;
	mulb_t       b_abs;
	logic [94:0] full_prod;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [61:0] ma_s1;
	logic [32:0] mb_s1;
	logic        neg_s1, neg_s2, neg_s3;
	logic [63:0] pl_s2, ph_s2;
	logic [61:0] mag_s3;
	val_t        prod_s4;

	assign a_abs = req.a[62] ? -req.a : req.a;
	assign b_abs = req.b[33] ? -req.b : req.b;
	assign full_prod = {ph_s2, 31'b0} + {31'b0, pl_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= req.start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1   <= a_abs[61:0];
		mb_s1   <= b_abs[32:0];
		neg_s1  <= req.a[62] ^ req.b[33];
		pl_s2   <= {33'b0, ma_s1[30:0]} * {31'b0, mb_s1};
		ph_s2   <= {33'b0, ma_s1[61:31]} * {31'b0, mb_s1};
		neg_s2  <= neg_s1;
		mag_s3  <= (|full_prod[94:FRAC_BITS+62]) ? SAT_POS[61:0]
			: full_prod[FRAC_BITS+61:FRAC_BITS];
		neg_s3  <= neg_s2;
		prod_s4 <= neg_s3 ? -$signed({1'b0, mag_s3}) : $signed({1'b0, mag_s3});
	end

	assign rsp.done = valid_s4;
	assign rsp.prod = prod_s4;

endmodule

@@ hdl/lflx_root.sv @@
// Sound speed unit: gamma*p/r by restoring division, then an integer square root.
module lflx_root #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lflx_pkg::HEAT_W-1:0]     heat,
	input  lflx_pkg::root_req_t             req,
	output lflx_pkg::root_rsp_t             rsp
);
	import lflx_pkg::*;

	localparam int SQ_SHIFT = 2 * FRAC_BITS - GAMMA_FRAC;
	localparam int WIDE_W   = NUM_W + 32;

	root_state_t      state_q, state_d;
	logic [31:0]      den_q, prs_q;
	logic [NUM_W-1:0] quo_q;
	logic [31:0]      rem_q;
	logic [5:0]       cnt_q;
	logic [63:0]      x_q, res_q, bit_q;
	logic             ovf_q;
	speed_t           speed_q;

	logic [32:0]      trial;
	logic             fits;
	logic [31:0]      rem_next;
	logic [NUM_W-1:0] quo_next;
	logic [WIDE_W-1:0] wide;
	logic [63:0]      root_sum;
	logic             root_fits;
	logic [63:0]      res_next;
	logic             div_last, sqrt_last;

	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		fits      = (trial >= {1'b0, den_q});
		rem_next  = fits ? (trial[31:0] - den_q) : trial[31:0];
		quo_next  = {quo_q[NUM_W-2:0], fits};
		wide      = WIDE_W'(quo_next) << SQ_SHIFT;
		root_sum  = res_q + bit_q;
		root_fits = (x_q >= root_sum);
		res_next  = root_fits ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		div_last  = (cnt_q == 6'(DIV_STEPS - 1));
		sqrt_last = (cnt_q == 6'(SQRT_STEPS - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RT_IDLE: begin
				if (req.start)
					state_d = (req.density == '0) ? RT_DONE : RT_MUL;
			end
			RT_MUL:  state_d = RT_DIV;
			RT_DIV:  state_d = div_last ? RT_SQRT : RT_DIV;
			RT_SQRT: state_d = sqrt_last ? RT_DONE : RT_SQRT;
			RT_DONE: state_d = RT_IDLE;
			default: state_d = RT_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = (state_q == RT_DONE);
		rsp.speed = speed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == RT_MUL || (state_q == RT_DIV && div_last))
				cnt_q <= '0;
			else if (state_q == RT_DIV || state_q == RT_SQRT)
				cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			RT_IDLE: begin
				if (req.start) begin
					den_q   <= req.density;
					prs_q   <= req.pressure;
					speed_q <= '0;
				end
			end
			RT_MUL: begin
				quo_q <= NUM_W'(heat) * NUM_W'(prs_q);
				rem_q <= '0;
			end
			RT_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (div_last) begin
					x_q   <= wide[63:0];
					ovf_q <= |wide[WIDE_W-1:63];
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			RT_SQRT: begin
				if (root_fits)
					x_q <= x_q - root_sum;
				res_q <= res_next;
				bit_q <= bit_q >> 2;
				if (sqrt_last)
					speed_q <= ovf_q ? SPEED_MAX : {1'b0, res_next[31:0]};
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/lflx_back.sv @@
// Back end: keeps the speed maxima and sequences the split flux arithmetic.
module lflx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cell_valid,
	input  lflx_pkg::cell_t     cell_data,
	output logic                cell_take,
	output lflx_pkg::root_req_t root_req,
	input  lflx_pkg::root_rsp_t root_rsp,
	output lflx_pkg::mul_req_t  mul_req,
	input  lflx_pkg::mul_rsp_t  mul_rsp,
	input  logic                pop,
	output logic                res_valid,
	output lflx_pkg::res_t      result
);
	import lflx_pkg::*;

	back_state_t state_q, state_d;
	step_t       step_q;
	cell_t       cell_q;
	val_t        ru_q, rv_q, ruv_q, f1_q, g2_q, epu_q, epv_q, sq_q;
	speed_t      maxx_q, maxy_q;
	logic signed [63:0] sum_p_q, sum_m_q;
	flux_t       plus_q [4];
	flux_t       minus_q [4];
	logic        out_full_q;
	res_t        out_q;

	step_t       idx;
	logic [1:0]  k;
	logic        dir;
	val_t        cq, fl;
	logic [32:0] ep_sum;
	logic signed [63:0] pp_sum;
	logic signed [32:0] u_ext, v_ext;
	logic [32:0] u_mag, v_mag;
	logic [33:0] sx_sum, sy_sum;
	speed_t      sx, sy, basex, basey;

	function automatic val_t sat63(input logic signed [63:0] x);
		val_t r;
		if (x > 64'(SAT_POS))
			r = SAT_POS;
		else if (x < -64'(SAT_POS))
			r = -SAT_POS;
		else
			r = 63'(x);
		return r;
	endfunction

	function automatic flux_t halve_clamp(input logic signed [63:0] x);
		logic signed [63:0] h;
		flux_t r;
		h = x + $signed({63'b0, x[63]});
		h = h >>> 1;
		if (h > 64'sh0000_7FFF_FFFF_FFFF)
			r = 48'sh7FFF_FFFF_FFFF;
		else if (h < 64'shFFFF_8000_0000_0000)
			r = 48'sh8000_0000_0000;
		else
			r = 48'(h);
		return r;
	endfunction

	always_comb begin
		idx    = step_q - STEP_SQ0;
		k      = idx[1:0];
		dir    = idx[2];
		ep_sum = {1'b0, cell_q.energy} + {1'b0, cell_q.pressure};
		pp_sum = 64'(mul_rsp.prod) + $signed(64'(cell_q.pressure));
		unique case (k)
			2'd0: cq = $signed({31'b0, cell_q.density});
			2'd1: cq = ru_q;
			2'd2: cq = rv_q;
			2'd3: cq = $signed({31'b0, cell_q.energy});
			default: cq = '0;
		endcase
		unique case (k)
			2'd0: fl = dir ? rv_q : ru_q;
			2'd1: fl = dir ? ruv_q : f1_q;
			2'd2: fl = dir ? g2_q : ruv_q;
			2'd3: fl = dir ? epv_q : epu_q;
			default: fl = '0;
		endcase
		u_ext  = 33'(cell_q.vel_x);
		v_ext  = 33'(cell_q.vel_y);
		u_mag  = u_ext[32] ? 33'(-u_ext) : 33'(u_ext);
		v_mag  = v_ext[32] ? 33'(-v_ext) : 33'(v_ext);
		sx_sum = {1'b0, u_mag} + {1'b0, root_rsp.speed};
		sy_sum = {1'b0, v_mag} + {1'b0, root_rsp.speed};
		sx     = sx_sum[33] ? SPEED_MAX : sx_sum[32:0];
		sy     = sy_sum[33] ? SPEED_MAX : sy_sum[32:0];
		basex  = cell_q.first ? '0 : maxx_q;
		basey  = cell_q.first ? '0 : maxy_q;
	end

	always_comb begin
		mul_req.start = (state_q == BK_ISSUE);
		unique case (step_q)
			STEP_RU: begin
				mul_req.a = $signed({31'b0, cell_q.density});
				mul_req.b = 34'(cell_q.vel_x);
			end
			STEP_RV: begin
				mul_req.a = $signed({31'b0, cell_q.density});
				mul_req.b = 34'(cell_q.vel_y);
			end
			STEP_RUV: begin
				mul_req.a = ru_q;
				mul_req.b = 34'(cell_q.vel_y);
			end
			STEP_RUU: begin
				mul_req.a = ru_q;
				mul_req.b = 34'(cell_q.vel_x);
			end
			STEP_RVV: begin
				mul_req.a = rv_q;
				mul_req.b = 34'(cell_q.vel_y);
			end
			STEP_EPU: begin
				mul_req.a = $signed({30'b0, ep_sum});
				mul_req.b = 34'(cell_q.vel_x);
			end
			STEP_EPV: begin
				mul_req.a = $signed({30'b0, ep_sum});
				mul_req.b = 34'(cell_q.vel_y);
			end
			default: begin
				mul_req.a = cq;
				mul_req.b = $signed({1'b0, dir ? maxy_q : maxx_q});
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cell_valid)
					state_d = (cell_data.kind == KIND_MEASURE) ? BK_ROOT : BK_ISSUE;
			end
			BK_ROOT: begin
				if (root_rsp.done)
					state_d = BK_IDLE;
			end
			BK_ISSUE: state_d = BK_WAIT;
			BK_WAIT: begin
				if (mul_rsp.done)
					state_d = (step_q >= STEP_SQ0) ? BK_SUM : BK_ISSUE;
			end
			BK_SUM:  state_d = BK_HALF;
			BK_HALF: state_d = (k == 2'd3) ? BK_EMIT : BK_ISSUE;
			BK_EMIT: begin
				if (!out_full_q)
					state_d = (step_q == STEP_END) ? BK_IDLE : BK_ISSUE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cell_take         = (state_q == BK_IDLE) && cell_valid;
		root_req.start    = cell_take && (cell_data.kind == KIND_MEASURE);
		root_req.density  = cell_data.density;
		root_req.pressure = cell_data.pressure;
		res_valid         = out_full_q;
		result            = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			step_q     <= '0;
			maxx_q     <= '0;
			maxy_q     <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cell_take)
				step_q <= STEP_RU;
			else if ((state_q == BK_WAIT && mul_rsp.done && step_q < STEP_SQ0)
				|| (state_q == BK_HALF && k != 2'd3)
				|| (state_q == BK_EMIT && !out_full_q && step_q != STEP_END))
				step_q <= step_q + 4'd1;
			if (state_q == BK_ROOT && root_rsp.done) begin
				maxx_q <= (sx > basex) ? sx : basex;
				maxy_q <= (sy > basey) ? sy : basey;
			end
			if (state_q == BK_EMIT && !out_full_q)
				out_full_q <= 1'b1;
			else if (pop && out_full_q)
				out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_take)
			cell_q <= cell_data;
		if (state_q == BK_WAIT && mul_rsp.done) begin
			unique case (step_q)
				STEP_RU:  ru_q  <= mul_rsp.prod;
				STEP_RV:  rv_q  <= mul_rsp.prod;
				STEP_RUV: ruv_q <= mul_rsp.prod;
				STEP_RUU: f1_q  <= sat63(pp_sum);
				STEP_RVV: g2_q  <= sat63(pp_sum);
				STEP_EPU: epu_q <= mul_rsp.prod;
				STEP_EPV: epv_q <= mul_rsp.prod;
				default:  sq_q  <= mul_rsp.prod;
			endcase
		end
		if (state_q == BK_SUM) begin
			sum_p_q <= 64'(fl) + 64'(sq_q);
			sum_m_q <= 64'(fl) - 64'(sq_q);
		end
		if (state_q == BK_HALF) begin
			plus_q[k]  <= halve_clamp(sum_p_q);
			minus_q[k] <= halve_clamp(sum_m_q);
		end
		if (state_q == BK_EMIT && !out_full_q) begin
			out_q.dir <= dir;
			for (int i = 0; i < 4; i++) begin
				out_q.plus[i]  <= plus_q[i];
				out_q.minus[i] <= minus_q[i];
			end
		end
	end

endmodule

@@ hdl/lax_friedrichs_flux_split_2d_unit.sv @@
// Top level of the Lax-Friedrichs flux splitting unit for 2D Euler cells.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  cell in  | push / full         | req_type first density pressure vel_x vel_y energy
//  flux out | empty / pop         | direction plus_* minus_* last
//  config   | cfg_valid/cfg_ready | heat_ratio
//
//  One cell is worked on at a time; up to two more wait in the input queue.
//  A measure cell holds the back end for 50 divider and 32 root steps;
//  with zero density it skips both and gets a zero speed.
//  A split cell runs 15 products through the shared 4-stage multiplier,
//  8 add/halve pairs and two result writes.
//  Reset clears the maxima and sets heat_ratio to 1.4; the back end stalls only at
//  the result register, while the front keeps taking cells until its queue fills.
module lax_friedrichs_flux_split_2d_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               req_type,
	input  logic               first,
	input  logic [31:0]        density,
	input  logic [31:0]        pressure,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [31:0]        energy,
	output logic               empty,
	input  logic               pop,
	output logic               direction,
	output logic signed [47:0] plus_mass,
	output logic signed [47:0] plus_mom_x,
	output logic signed [47:0] plus_mom_y,
	output logic signed [47:0] plus_energy,
	output logic signed [47:0] minus_mass,
	output logic signed [47:0] minus_mom_x,
	output logic signed [47:0] minus_mom_y,
	output logic signed [47:0] minus_energy,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [17:0]        heat_ratio
);
	import lflx_pkg::*;

	logic [HEAT_W-1:0] heat_q;
	logic              cell_valid;
	cell_t             cell_data;
	logic              cell_take;
	root_req_t         root_req;
	root_rsp_t         root_rsp;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	logic              res_valid;
	res_t              result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			heat_q <= HEAT_RESET;
		else if (cfg_valid && cfg_ready)
			heat_q <= heat_ratio;
	end

	lflx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.first      (first),
		.density    (density),
		.pressure   (pressure),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.energy     (energy),
		.cell_valid (cell_valid),
		.cell_data  (cell_data),
		.cell_take  (cell_take)
	);

	lflx_root #(.FRAC_BITS(FRAC_BITS)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.heat   (heat_q),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	lflx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	lflx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_data  (cell_data),
		.cell_take  (cell_take),
		.root_req   (root_req),
		.root_rsp   (root_rsp),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.pop        (pop),
		.res_valid  (res_valid),
		.result     (result)
	);

	assign empty        = ~res_valid;
	assign direction    = result.dir;
	assign last         = result.dir;
	assign plus_mass    = result.plus[0];
	assign plus_mom_x   = result.plus[1];
	assign plus_mom_y   = result.plus[2];
	assign plus_energy  = result.plus[3];
	assign minus_mass   = result.minus[0];
	assign minus_mom_x  = result.minus[1];
	assign minus_mom_y  = result.minus[2];
	assign minus_energy = result.minus[3];

endmodule

@@ hdl/lflx_checker.sv @@
// Port-level checks for the flux splitting unit, bound to the top level.
module lflx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               req_type,
	input logic               first,
	input logic [31:0]        density,
	input logic [31:0]        pressure,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] vel_y,
	input logic [31:0]        energy,
	input logic               empty,
	input logic               pop,
	input logic               direction,
	input logic signed [47:0] plus_mass,
	input logic signed [47:0] plus_mom_x,
	input logic signed [47:0] plus_mom_y,
	input logic signed [47:0] plus_energy,
	input logic signed [47:0] minus_mass,
	input logic signed [47:0] minus_mom_x,
	input logic signed [47:0] minus_mom_y,
	input logic signed [47:0] minus_energy,
	input logic               last,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [17:0]        heat_ratio
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result visible after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(direction) && $stable(plus_mass)
			&& $stable(minus_energy))
		else $error("waiting result changed");

	a_last_dir: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> last == direction)
		else $error("last does not match direction");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop |=> empty)
		else $error("result register refilled in the transfer cycle");

endmodule

bind lax_friedrichs_flux_split_2d_unit lflx_checker u_checker (.*);
